[rtl/pinhole_point_projection_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the projection block
// Immediate-consequence and next-cycle implication checks on one clock.
// ----------------------------------------------------------------------------
`ifndef PINHOLE_POINT_PROJECTION_MACROS_SVH
`define PINHOLE_POINT_PROJECTION_MACROS_SVH

// ante holds, cons holds in the same cycle
`define PPP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// ante holds, cons holds in the next cycle
`define PPP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ppp_pkg.sv]
// ----------------------------------------------------------------------------
// ppp_pkg
// Types and constants shared by the projection front end, back end and top.
// ----------------------------------------------------------------------------
package ppp_pkg;

  localparam int unsigned PT_W   = 24;
  localparam int unsigned ROT_W  = 16;
  localparam int unsigned TR_W   = 21;
  localparam int unsigned FOC_W  = 24;
  localparam int unsigned DIM_W  = 16;
  localparam int unsigned PROD_W = ROT_W + PT_W;
  localparam int unsigned CAM_W  = 41;
  localparam int unsigned MAG_W  = CAM_W - 1;
  localparam int unsigned HALF_W = MAG_W / 2;
  localparam int unsigned PL_W   = HALF_W + FOC_W;
  localparam int unsigned NUM_W  = 64;
  localparam int unsigned DEN_W  = MAG_W + 4;
  localparam int unsigned QUO_W  = 22;
  localparam int unsigned CMP_W  = DEN_W + QUO_W;
  localparam int unsigned OUT_W  = 20;
  localparam int unsigned SUM_W  = 25;
  localparam int unsigned TR_SH  = 13;
  localparam logic [QUO_W:0] OFFSET_CAP = (QUO_W + 1)'(1) << (QUO_W - 1);
  localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'(524287);
  localparam logic signed [SUM_W-1:0] OUT_MIN = -SUM_W'(524288);

  typedef enum logic [2:0] {
    REG_ROT_X  = 3'd0,
    REG_ROT_Y  = 3'd1,
    REG_ROT_Z  = 3'd2,
    REG_TRANS  = 3'd3,
    REG_FOCAL  = 3'd4,
    REG_COLS   = 3'd5,
    REG_ROWS   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [2:0][2:0][ROT_W-1:0] rot;
    logic [2:0][TR_W-1:0]       trans;
    logic [FOC_W-1:0]           focal;
    logic [DIM_W-1:0]           cols;
    logic [DIM_W-1:0]           rows;
  } cfg_t;

  typedef struct packed {
    logic                       invalid;
    logic [2:0][CAM_W-1:0]      c;
  } cam_t;

  typedef struct packed {
    logic [OUT_W-1:0]           pixel_x;
    logic [OUT_W-1:0]           pixel_y;
    logic                       depth_invalid;
    logic                       saturated;
  } res_t;

  typedef struct packed {
    logic [NUM_W-1:0]           rem;
    logic [QUO_W-1:0]           quo;
    logic                       neg;
    logic                       ovf;
  } lane_t;

endpackage

[rtl/ppp_fifo.sv]
// ----------------------------------------------------------------------------
// ppp_fifo
// Small register queue with combinational head read.
// ----------------------------------------------------------------------------
module ppp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign full_o  = (cnt_q == FULL_CNT);
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LAST) ? '0 : wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LAST) ? '0 : rd_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

[rtl/ppp_front.sv]
// ----------------------------------------------------------------------------
// ppp_front
// Rotate and translate a world point into camera space; flag bad depth.
// ----------------------------------------------------------------------------
module ppp_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ppp_pkg::cfg_t                cfg_i,
  input  logic                         en_i,
  input  logic                         in_valid_i,
  input  logic [ppp_pkg::PT_W-1:0]     point_x_i,
  input  logic [ppp_pkg::PT_W-1:0]     point_y_i,
  input  logic [ppp_pkg::PT_W-1:0]     point_z_i,
  output logic                         out_valid_o,
  output ppp_pkg::cam_t                out_o
);
  import ppp_pkg::*;

  logic signed [PT_W-1:0]   pt [3];
  logic signed [PROD_W-1:0] prod_d [3][3];
  logic signed [PROD_W-1:0] prod_q [3][3];
  logic                     v0_q, v1_q;
  cam_t                     cam_d, cam_q;

  assign pt[0] = $signed(point_x_i);
  assign pt[1] = $signed(point_y_i);
  assign pt[2] = $signed(point_z_i);

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r][c] = $signed(cfg_i.rot[r][c]) * pt[c];
      end
    end
  end

  always_comb begin
    logic signed [CAM_W-1:0] acc;
    for (int r = 0; r < 3; r++) begin
      acc = CAM_W'(prod_q[r][0]) + CAM_W'(prod_q[r][1]) + CAM_W'(prod_q[r][2])
          + (CAM_W'($signed(cfg_i.trans[r])) <<< TR_SH);
      cam_d.c[r] = acc;
    end
    cam_d.invalid = ($signed(cam_d.c[2]) <= $signed(CAM_W'(0)));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      cam_q  <= cam_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
    end
  end

  assign out_valid_o = v1_q;
  assign out_o       = cam_q;

endmodule

[rtl/ppp_back.sv]
// ----------------------------------------------------------------------------
// ppp_back
// Scale by focal length, divide by depth one quotient bit per stage, round,
// cap, add the image centre and clamp.
// ----------------------------------------------------------------------------
module ppp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ppp_pkg::cfg_t  cfg_i,
  input  logic           en_i,
  input  logic           in_valid_i,
  input  ppp_pkg::cam_t  in_i,
  output logic           out_valid_o,
  output ppp_pkg::res_t  out_o
);
  import ppp_pkg::*;

  localparam int unsigned NS = QUO_W + 1;

  logic [PL_W-1:0]  plo_q [2];
  logic [PL_W-1:0]  phi_q [2];
  logic             neg0_q [2];
  logic [DEN_W-1:0] den0_q;
  logic             inv0_q, v0_q;

  lane_t            lane_d [NS][2];
  lane_t            lane_q [NS][2];
  logic [DEN_W-1:0] den_q [NS];
  logic             inv_q [NS];
  logic             v_q [NS];

  always_ff @(posedge clk_i) begin
    logic [MAG_W-1:0] mag;
    logic             neg;
    if (en_i) begin
      for (int l = 0; l < 2; l++) begin
        neg = in_i.c[l][CAM_W-1];
        mag = neg ? MAG_W'(-in_i.c[l]) : in_i.c[l][MAG_W-1:0];
        plo_q[l]  <= PL_W'(mag[HALF_W-1:0]) * PL_W'(cfg_i.focal);
        phi_q[l]  <= PL_W'(mag[MAG_W-1:HALF_W]) * PL_W'(cfg_i.focal);
        neg0_q[l] <= neg;
      end
      den0_q <= {in_i.c[2][MAG_W-1:0], 4'b0};
      inv0_q <= in_i.invalid;
    end
  end

  always_comb begin
    logic [NUM_W-1:0] num;
    logic [CMP_W-1:0] trial;
    logic             ge;
    for (int l = 0; l < 2; l++) begin
      num = NUM_W'(plo_q[l]) + (NUM_W'(phi_q[l]) << HALF_W);
      lane_d[0][l].rem = num;
      lane_d[0][l].quo = '0;
      lane_d[0][l].neg = neg0_q[l];
      lane_d[0][l].ovf = (CMP_W'(num) >= (CMP_W'(den0_q) << QUO_W));
    end
    for (int s = 0; s < QUO_W; s++) begin
      for (int l = 0; l < 2; l++) begin
        trial = CMP_W'(den_q[s]) << (QUO_W - 1 - s);
        ge = (CMP_W'(lane_q[s][l].rem) >= trial);
        lane_d[s+1][l] = lane_q[s][l];
        if (ge) begin
          lane_d[s+1][l].rem = lane_q[s][l].rem - trial[NUM_W-1:0];
        end
        lane_d[s+1][l].quo[QUO_W-1-s] = ge;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q[0] <= lane_d[0];
      den_q[0]  <= den0_q;
      inv_q[0]  <= inv0_q;
      for (int s = 1; s < NS; s++) begin
        lane_q[s] <= lane_d[s];
        den_q[s]  <= den_q[s-1];
        inv_q[s]  <= inv_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      for (int s = 0; s < NS; s++) begin
        v_q[s] <= 1'b0;
      end
    end else if (en_i) begin
      v0_q   <= in_valid_i;
      v_q[0] <= v0_q;
      for (int s = 1; s < NS; s++) begin
        v_q[s] <= v_q[s-1];
      end
    end
  end

  always_comb begin
    lane_t                   ln;
    logic                    rnd;
    logic [QUO_W:0]          qr;
    logic [QUO_W:0]          mag;
    logic [DIM_W-1:0]        dim;
    logic signed [SUM_W-1:0] off, ctr, tot;
    logic [OUT_W-1:0]        pix [2];
    logic                    sat;
    sat = 1'b0;
    for (int l = 0; l < 2; l++) begin
      ln  = lane_q[NS-1][l];
      dim = (l == 0) ? cfg_i.cols : cfg_i.rows;
      rnd = ({ln.rem, 1'b0} >= (NUM_W + 1)'(den_q[NS-1]));
      qr  = {1'b0, ln.quo} + (QUO_W + 1)'(rnd);
      mag = (ln.ovf || qr > OFFSET_CAP) ? OFFSET_CAP : qr;
      off = ln.neg ? -$signed(SUM_W'(mag)) : $signed(SUM_W'(mag));
      ctr = $signed(SUM_W'({dim[DIM_W-1:1], 4'b0}));
      tot = off + ctr;
      if (tot > OUT_MAX) begin
        pix[l] = OUT_MAX[OUT_W-1:0];
        sat    = 1'b1;
      end else if (tot < OUT_MIN) begin
        pix[l] = OUT_MIN[OUT_W-1:0];
        sat    = 1'b1;
      end else begin
        pix[l] = tot[OUT_W-1:0];
      end
    end
    if (inv_q[NS-1]) begin
      out_o.pixel_x       = '0;
      out_o.pixel_y       = '0;
      out_o.depth_invalid = 1'b1;
      out_o.saturated     = 1'b0;
    end else begin
      out_o.pixel_x       = pix[0];
      out_o.pixel_y       = pix[1];
      out_o.depth_invalid = 1'b0;
      out_o.saturated     = sat;
    end
  end

  assign out_valid_o = v_q[NS-1];

endmodule

[rtl/pinhole_point_projection.sv]
// ----------------------------------------------------------------------------
// pinhole_point_projection
// Perspective projection of world points to Q16.4 pixel positions.
//
//   channel  | handshake          | words
//   ---------+--------------------+-----------------------------------------
//   points   | push / full        | point_x_i, point_y_i, point_z_i
//   pixels   | pop / empty        | pixel_x_o, pixel_y_o, depth_invalid_o,
//            |                    | saturated_o
//   config   | cfg_we_i           | cfg_idx_i, cfg_data_i
//
// One point per cycle sustained while neither queue fills. Push to empty low:
// camera transform (product and sum registers), one queue slot, focal
// scaling, one quotient bit per stage over 22 divider stages, output queue.
// A full output queue stalls the divider pipeline; a full mid queue stalls
// the transform and raises full. Reset clears the pipelines and queues and
// loads the identity camera.
// ----------------------------------------------------------------------------
`include "pinhole_point_projection_macros.svh"

module pinhole_point_projection #(
  parameter int unsigned MID_DEPTH = 4,
  parameter int unsigned OUT_DEPTH = 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_idx_i,
  input  logic [63:0]                 cfg_data_i,
  input  logic                        push,
  output logic                        full,
  input  logic [ppp_pkg::PT_W-1:0]    point_x_i,
  input  logic [ppp_pkg::PT_W-1:0]    point_y_i,
  input  logic [ppp_pkg::PT_W-1:0]    point_z_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [ppp_pkg::OUT_W-1:0]   pixel_x_o,
  output logic [ppp_pkg::OUT_W-1:0]   pixel_y_o,
  output logic                        depth_invalid_o,
  output logic                        saturated_o
);
  import ppp_pkg::*;

  logic [63:0]      rot_x_q, rot_y_q, rot_z_q;
  logic [62:0]      trans_q;
  logic [FOC_W-1:0] focal_q;
  logic [DIM_W-1:0] cols_q, rows_q;
  cfg_t             cfg;

  logic             front_en, front_v, mid_push, mid_pop, mid_full, mid_empty;
  cam_t             front_cam, mid_cam;
  logic             back_en, back_v, out_push, out_full;
  res_t             back_res, out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_x_q <= 64'd8192;
      rot_y_q <= 64'd536870912;
      rot_z_q <= 64'd35184372088832;
      trans_q <= '0;
      focal_q <= FOC_W'(128000);
      cols_q  <= DIM_W'(640);
      rows_q  <= DIM_W'(480);
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_ROT_X: rot_x_q <= cfg_data_i;
        REG_ROT_Y: rot_y_q <= cfg_data_i;
        REG_ROT_Z: rot_z_q <= cfg_data_i;
        REG_TRANS: trans_q <= cfg_data_i[62:0];
        REG_FOCAL: focal_q <= cfg_data_i[FOC_W-1:0];
        REG_COLS:  cols_q  <= cfg_data_i[DIM_W-1:0];
        REG_ROWS:  rows_q  <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.rot[0] = {rot_x_q[47:32], rot_x_q[31:16], rot_x_q[15:0]};
    cfg.rot[1] = {rot_y_q[47:32], rot_y_q[31:16], rot_y_q[15:0]};
    cfg.rot[2] = {rot_z_q[47:32], rot_z_q[31:16], rot_z_q[15:0]};
    cfg.trans  = {trans_q[62:42], trans_q[41:21], trans_q[20:0]};
    cfg.focal  = focal_q;
    cfg.cols   = cols_q;
    cfg.rows   = rows_q;
  end

  assign full     = front_v && mid_full;
  assign front_en = !full;
  assign mid_push = front_v && !mid_full;

  ppp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .en_i        (front_en),
    .in_valid_i  (push),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .point_z_i   (point_z_i),
    .out_valid_o (front_v),
    .out_o       (front_cam)
  );

  ppp_fifo #(
    .WIDTH ($bits(cam_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (front_cam),
    .pop_i   (mid_pop),
    .data_o  (mid_cam),
    .full_o  (mid_full),
    .empty_o (mid_empty)
  );

  assign back_en  = !(back_v && out_full);
  assign mid_pop  = back_en && !mid_empty;
  assign out_push = back_v && !out_full;

  ppp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .en_i        (back_en),
    .in_valid_i  (!mid_empty),
    .in_i        (mid_cam),
    .out_valid_o (back_v),
    .out_o       (back_res)
  );

  ppp_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (back_res),
    .pop_i   (pop),
    .data_o  (out_res),
    .full_o  (out_full),
    .empty_o (empty)
  );

  assign pixel_x_o       = out_res.pixel_x;
  assign pixel_y_o       = out_res.pixel_y;
  assign depth_invalid_o = out_res.depth_invalid;
  assign saturated_o     = out_res.saturated;

  `PPP_ASSERT_IMP(a_mid_no_overrun, clk_i, rst_ni, mid_push, !mid_full, "mid queue overrun")
  `PPP_ASSERT_IMP(a_out_no_overrun, clk_i, rst_ni, out_push, !out_full, "out queue overrun")
  `PPP_ASSERT_IMP(a_invalid_zero, clk_i, rst_ni, !empty && depth_invalid_o, pixel_x_o == '0 && pixel_y_o == '0 && !saturated_o, "bad depth word not zeroed")
  `PPP_ASSERT_NXT(a_back_hold, clk_i, rst_ni, back_v && !back_en, back_v, "stalled result lost")

endmodule
